/* rtl/core/text_sprite_command_port_assert.svh */
// Assertion helpers for the text and sprite command port.
// Both sample on the rising clock edge and are held off while reset is asserted.
`ifndef TEXT_SPRITE_COMMAND_PORT_ASSERT_SVH
`define TEXT_SPRITE_COMMAND_PORT_ASSERT_SVH

// A property that must hold at every sampled edge.
`define TSCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TSCP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tscp_pkg.sv */
package tscp_pkg;

	// Parameter buffer
	localparam int SYNC_PARAM_BYTES = 14;
	localparam int BUF_DEPTH        = 14;
	localparam int IDX_W            = 4;

	// Access kinds carried in tuser
	localparam logic [1:0] MODE_CMD    = 2'd0;
	localparam logic [1:0] MODE_PARAM  = 2'd1;
	localparam logic [1:0] MODE_STATUS = 2'd2;
	localparam logic [1:0] MODE_DATA   = 2'd3;

	// Command bytes
	localparam logic [7:0] OP_TIMING      = 8'h10;
	localparam logic [7:0] OP_DISPLAY_ON  = 8'h12;
	localparam logic [7:0] OP_DISPLAY_DEF = 8'h14;
	localparam logic [7:0] OP_CURSOR_DEF  = 8'h15;
	localparam logic [7:0] OP_SPRITE_ON   = 8'h82;
	localparam logic [7:0] OP_SPRITE_DEF  = 8'h84;

	// Parameter counts per command
	localparam logic [IDX_W-1:0] CNT_SYNC   = IDX_W'(SYNC_PARAM_BYTES);
	localparam logic [IDX_W-1:0] CNT_DSPON  = 4'd3;
	localparam logic [IDX_W-1:0] CNT_DSPDEF = 4'd6;
	localparam logic [IDX_W-1:0] CNT_CURDEF = 4'd1;
	localparam logic [IDX_W-1:0] CNT_SPRON  = 4'd3;

	// Completed-command codes
	localparam logic [2:0] DONE_NONE   = 3'd0;
	localparam logic [2:0] DONE_SYNC   = 3'd1;
	localparam logic [2:0] DONE_DSPON  = 3'd2;
	localparam logic [2:0] DONE_DSPDEF = 3'd3;
	localparam logic [2:0] DONE_CURDEF = 3'd4;
	localparam logic [2:0] DONE_SPRON  = 3'd5;

	// Memory operations
	localparam logic [1:0] MEMOP_NONE  = 2'd0;
	localparam logic [1:0] MEMOP_WRITE = 2'd1;
	localparam logic [1:0] MEMOP_SET   = 2'd2;
	localparam logic [1:0] MEMOP_CLR   = 2'd3;

	localparam logic [7:0] CURSOR_MASK = 8'h02;
	localparam logic [7:0] DATA_READ   = 8'hFF;

	// Parameter byte handling
	typedef enum logic [3:0] {
		HND_IDLE       = 4'b0001,
		HND_COUNTED    = 4'b0010,
		HND_SPR_OFFSET = 4'b0100,
		HND_SPR_DATA   = 4'b1000
	} handler_t;

	typedef logic [7:0] param_buf_t [BUF_DEPTH];

	typedef struct packed {
		logic [7:0]  read_data;
		logic        busy_res;
		logic [1:0]  mem_op;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic [2:0]  done_command;
		logic [15:0] value_a;
		logic [8:0]  value_b;
		logic [7:0]  value_c;
		logic [4:0]  value_d;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic [8:0] lines;
	} dec_t;

endpackage

/* rtl/core/tscp_decode.sv */
module tscp_decode (
	input  logic [2:0]          pending,
	input  tscp_pkg::param_buf_t p,
	input  logic [7:0]          sprite_high,
	input  logic [8:0]          screen_lines,
	output tscp_pkg::dec_t      dec
);
	import tscp_pkg::*;

	logic [8:0] lines;

	assign lines = {p[11][6], p[10]};

	// Turn the filled parameter buffer into the fields of the finished command
	always_comb begin
		dec = '0;
		dec.lines = lines;
		dec.res.done_command = pending;
		unique case (pending)
			DONE_SYNC: begin
				dec.res.value_a = 16'(lines);
				dec.res.value_b = 9'(p[0][7:6] == 2'b10);
				dec.res.value_c = 8'(lines != screen_lines);
			end
			DONE_DSPON: begin
				dec.res.value_a = {p[0], 8'h00};
			end
			DONE_DSPDEF: begin
				dec.res.value_a = {p[1], p[0]};
				dec.res.value_b = 9'(p[3]) + 9'd1;
				dec.res.value_c = p[4];
				dec.res.value_d = p[5][7:3];
			end
			DONE_CURDEF: begin
				dec.res.value_a     = 16'(p[0][7:3]);
				dec.res.value_b     = 9'(p[0][0]);
				dec.res.mem_op      = p[0][1] ? MEMOP_SET : MEMOP_CLR;
				dec.res.mem_address = {sprite_high, p[0][7:3], 3'b001};
				dec.res.mem_data    = CURSOR_MASK;
			end
			DONE_SPRON: begin
				dec.res.value_a = {p[0], 8'h00};
				dec.res.value_b = 9'(p[2][7:3]);
				dec.res.value_c = 8'(p[2][1]);
				dec.res.value_d = 5'(p[2][0]);
			end
			default: begin
				dec.res.done_command = DONE_NONE;
			end
		endcase
	end

endmodule

/* rtl/core/text_sprite_command_port.sv */
// Command and parameter front end of a text and sprite display processor.
// One bus access is taken as a beat on the slave side: tuser selects command
// write, parameter write, status read or data port read, and every beat gives
// exactly one result beat on the master side. A beat passes an input register
// and a result register, and the result register holds it until the master side
// takes it; one beat is taken every cycle while the master side is not stalled.
// Counted commands report their decoded fields on the beat of their last
// parameter byte; after SPRDEF every parameter byte after the offset becomes a
// sprite memory write request and busy stays set until the next command. Reads
// return busy in bit 2 and vsync in bit 6, or all ones for the data port.
`include "text_sprite_command_port_assert.svh"

module text_sprite_command_port (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [8] vsync_active, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] read_data, [8] busy_res, [10:9] mem_op, [26:11] mem_address,
	// [34:27] mem_data, [37:35] done_command, [53:38] value_a, [62:54] value_b,
	// [70:63] value_c, [75:71] value_d, rest zero
	output logic [79:0] m_axis_tdata
);
	import tscp_pkg::*;

	logic             in_valid_s1;
	logic [1:0]       mode_s1;
	logic [7:0]       data_s1;
	logic             vsync_s1;

	handler_t         handler_q, handler_n;
	logic [IDX_W-1:0] remaining_q, remaining_n;
	logic [IDX_W-1:0] index_q, index_n;
	logic [2:0]       pending_q, pending_n;
	logic             busy_q, busy_n;
	logic [8:0]       lines_q, lines_n;
	logic [7:0]       sprite_high_q, sprite_high_n;
	logic [15:0]      offset_q, offset_n;
	param_buf_t       buf_q;
	param_buf_t       p_view;

	logic             out_valid_q;
	res_t             res_q, res_n;
	logic             advance;
	logic             buf_we;
	logic             decode_en;
	dec_t             dec;

	// Move a beat from the input register when the result register frees up
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	// Capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1  <= s_axis_tuser;
			data_s1  <= s_axis_tdata[7:0];
			vsync_s1 <= s_axis_tdata[8];
		end
	end

	// Buffer as seen by the decode, including the byte written this beat
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			p_view[i] = (buf_we && index_q == IDX_W'(i)) ? data_s1 : buf_q[i];
		end
	end

	tscp_decode u_decode (
		.pending      (pending_q),
		.p            (p_view),
		.sprite_high  (sprite_high_q),
		.screen_lines (lines_q),
		.dec          (dec)
	);

	// Next state and result for the beat in the input register
	always_comb begin
		handler_n     = handler_q;
		remaining_n   = remaining_q;
		index_n       = index_q;
		pending_n     = pending_q;
		busy_n        = busy_q;
		lines_n       = lines_q;
		sprite_high_n = sprite_high_q;
		offset_n      = offset_q;
		buf_we        = 1'b0;
		decode_en     = 1'b0;
		res_n         = '0;

		unique case (mode_s1)
			MODE_CMD: begin
				index_n = '0;
				busy_n  = 1'b1;
				unique case (data_s1)
					OP_TIMING: begin
						remaining_n = CNT_SYNC;
						pending_n   = DONE_SYNC;
						handler_n   = HND_COUNTED;
					end
					OP_DISPLAY_ON: begin
						remaining_n = CNT_DSPON;
						pending_n   = DONE_DSPON;
						handler_n   = HND_COUNTED;
					end
					OP_DISPLAY_DEF: begin
						remaining_n = CNT_DSPDEF;
						pending_n   = DONE_DSPDEF;
						handler_n   = HND_COUNTED;
					end
					OP_CURSOR_DEF: begin
						remaining_n = CNT_CURDEF;
						pending_n   = DONE_CURDEF;
						handler_n   = HND_COUNTED;
					end
					OP_SPRITE_ON: begin
						remaining_n = CNT_SPRON;
						pending_n   = DONE_SPRON;
						handler_n   = HND_COUNTED;
					end
					OP_SPRITE_DEF: begin
						handler_n = HND_SPR_OFFSET;
					end
					default: begin
						handler_n = HND_IDLE;
						busy_n    = 1'b0;
					end
				endcase
			end
			MODE_PARAM: begin
				unique case (handler_q)
					HND_COUNTED: begin
						if (remaining_q != '0) begin
							buf_we      = index_q < IDX_W'(BUF_DEPTH);
							index_n     = index_q + IDX_W'(1);
							remaining_n = remaining_q - IDX_W'(1);
							if (remaining_q == IDX_W'(1)) begin
								handler_n = HND_IDLE;
								decode_en = 1'b1;
								busy_n    = 1'b0;
							end
						end
					end
					HND_SPR_OFFSET: begin
						offset_n  = 16'(data_s1);
						handler_n = HND_SPR_DATA;
					end
					HND_SPR_DATA: begin
						res_n.mem_op      = MEMOP_WRITE;
						res_n.mem_address = {sprite_high_q, 8'h00} + offset_q;
						res_n.mem_data    = data_s1;
						offset_n          = offset_q + 16'd1;
					end
					default: begin
					end
				endcase
			end
			MODE_STATUS: begin
				res_n.read_data = {1'b0, vsync_s1, 3'b000, busy_q, 2'b00};
			end
			default: begin
				res_n.read_data = DATA_READ;
			end
		endcase

		// Take the decoded fields of a finished command
		if (decode_en) begin
			res_n = dec.res;
			if (dec.res.done_command == DONE_SYNC) begin
				lines_n = dec.lines;
			end
			if (dec.res.done_command == DONE_SPRON) begin
				sprite_high_n = p_view[0];
			end
		end
		res_n.busy_res = busy_n;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q     <= HND_IDLE;
			remaining_q   <= '0;
			index_q       <= '0;
			pending_q     <= DONE_NONE;
			busy_q        <= 1'b0;
			lines_q       <= '0;
			sprite_high_q <= '0;
			offset_q      <= '0;
		end else if (advance) begin
			handler_q     <= handler_n;
			remaining_q   <= remaining_n;
			index_q       <= index_n;
			pending_q     <= pending_n;
			busy_q        <= busy_n;
			lines_q       <= lines_n;
			sprite_high_q <= sprite_high_n;
			offset_q      <= offset_n;
		end
	end

	// Parameter buffer
	always_ff @(posedge clk) begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			if (advance && buf_we && index_q == IDX_W'(i)) begin
				buf_q[i] <= data_s1;
			end
		end
	end

	// Result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, res_q.value_d, res_q.value_c, res_q.value_b,
		res_q.value_a, res_q.done_command, res_q.mem_data, res_q.mem_address,
		res_q.mem_op, res_q.busy_res, res_q.read_data};

	// Busy tracks whether parameter bytes are still expected
	`TSCP_ASSERT(a_busy_handler, busy_q == (handler_q != HND_IDLE), "busy out of step with handler")
	`TSCP_ASSERT_IMP(a_counted_left, handler_q == HND_COUNTED, remaining_q != '0,
		"counted handler with no bytes left")
	`TSCP_ASSERT_IMP(a_done_not_busy, out_valid_q && res_q.done_command != DONE_NONE,
		!res_q.busy_res, "finished command still reports busy")

endmodule

/* bench/text_sprite_command_port_tb.sv */
`timescale 1ns / 1ps

module text_sprite_command_port_tb;

	import tscp_pkg::*;

	localparam logic [7:0] OP_EXIT = 8'h88;
	localparam int ITEMS_PER_PHASE = 500;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 10;

	// Predicts every reply beat of the command port and checks the replies in order
	class command_port_model;
		res_t       replies [$];
		logic [7:0] params [BUF_DEPTH];
		logic [3:0] remaining;
		logic [3:0] index;
		handler_t   handler;
		logic [2:0] pending;
		logic       busy;
		logic [8:0] screen_lines;
		logic [7:0] table_high;
		logic [15:0] spr_offset;
		int         fails;
		int         accesses;
		int         decoded;
		int         mem_requests;

		function new();
			foreach (params[i])
				params[i] = 8'h00;
			remaining    = '0;
			index        = '0;
			handler      = HND_IDLE;
			pending      = DONE_NONE;
			busy         = 1'b0;
			screen_lines = '0;
			table_high   = '0;
			spr_offset   = '0;
			fails        = 0;
			accesses     = 0;
			decoded      = 0;
			mem_requests = 0;
		endfunction

		function void arm(logic [3:0] count, logic [2:0] code);
			remaining = count;
			pending   = code;
			handler   = HND_COUNTED;
		endfunction

		function void start_command(logic [7:0] cmd);
			index = '0;
			busy  = 1'b1;
			case (cmd)
				OP_TIMING:      arm(CNT_SYNC, DONE_SYNC);
				OP_DISPLAY_ON:  arm(CNT_DSPON, DONE_DSPON);
				OP_DISPLAY_DEF: arm(CNT_DSPDEF, DONE_DSPDEF);
				OP_CURSOR_DEF:  arm(CNT_CURDEF, DONE_CURDEF);
				OP_SPRITE_ON:   arm(CNT_SPRON, DONE_SPRON);
				OP_SPRITE_DEF:  handler = HND_SPR_OFFSET;
				default: begin
					handler = HND_IDLE;
					busy    = 1'b0;
				end
			endcase
		endfunction

		// Decode the filled buffer on the last parameter byte
		function void finish_command(inout res_t r);
			logic [8:0] lines;
			r.done_command = pending;
			case (pending)
				DONE_SYNC: begin
					lines     = {params[11][6], params[10]};
					r.value_a = 16'(lines);
					r.value_b = 9'(params[0][7:6] == 2'b10);
					if (lines != screen_lines) begin
						screen_lines = lines;
						r.value_c    = 8'd1;
					end
				end
				DONE_DSPON: r.value_a = {params[0], 8'h00};
				DONE_DSPDEF: begin
					r.value_a = {params[1], params[0]};
					r.value_b = 9'(params[3]) + 9'd1;
					r.value_c = params[4];
					r.value_d = params[5][7:3];
				end
				DONE_CURDEF: begin
					r.value_a     = 16'(params[0][7:3]);
					r.value_b     = 9'(params[0][0]);
					r.mem_op      = params[0][1] ? MEMOP_SET : MEMOP_CLR;
					r.mem_address = {table_high, 8'h00} + {8'h00, params[0][7:3], 3'b001};
					r.mem_data    = CURSOR_MASK;
				end
				DONE_SPRON: begin
					table_high = params[0];
					r.value_a  = {params[0], 8'h00};
					r.value_b  = 9'(params[2][7:3]);
					r.value_c  = 8'(params[2][1]);
					r.value_d  = 5'(params[2][0]);
				end
				default: r.done_command = DONE_NONE;
			endcase
			if (r.done_command != DONE_NONE)
				decoded++;
			busy = 1'b0;
		endfunction

		function void take_param(logic [7:0] data, inout res_t r);
			case (handler)
				HND_COUNTED: begin
					if (remaining != '0) begin
						if (index < BUF_DEPTH)
							params[index] = data;
						index     = index + 4'd1;
						remaining = remaining - 4'd1;
						if (remaining == '0) begin
							handler = HND_IDLE;
							finish_command(r);
						end
					end
				end
				HND_SPR_OFFSET: begin
					spr_offset = {8'h00, data};
					handler    = HND_SPR_DATA;
				end
				HND_SPR_DATA: begin
					r.mem_op      = MEMOP_WRITE;
					r.mem_address = {table_high, 8'h00} + spr_offset;
					r.mem_data    = data;
					spr_offset    = spr_offset + 16'd1;
				end
				default: ;
			endcase
		endfunction

		// Note an accepted access and queue the reply it should produce
		function void note_access(logic [1:0] mode, logic [7:0] data, logic vs);
			res_t r;
			r = '0;
			accesses++;
			case (mode)
				MODE_CMD:    start_command(data);
				MODE_PARAM:  take_param(data, r);
				MODE_STATUS: r.read_data = {1'b0, vs, 3'b000, busy, 2'b00};
				default:     r.read_data = DATA_READ;
			endcase
			if (r.mem_op != MEMOP_NONE)
				mem_requests++;
			r.busy_res = busy;
			replies.push_back(r);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
				fails++;
			end
		endfunction

		function void check_reply(logic [79:0] bits);
			res_t want;
			res_t got;
			if (replies.size() == 0) begin
				$display("%0t: reply beat %h with nothing expected", $time, bits);
				fails++;
				return;
			end
			want             = replies.pop_front();
			got.read_data    = bits[7:0];
			got.busy_res     = bits[8];
			got.mem_op       = bits[10:9];
			got.mem_address  = bits[26:11];
			got.mem_data     = bits[34:27];
			got.done_command = bits[37:35];
			got.value_a      = bits[53:38];
			got.value_b      = bits[62:54];
			got.value_c      = bits[70:63];
			got.value_d      = bits[75:71];
			compare("read_data", 16'(want.read_data), 16'(got.read_data));
			compare("busy_res", 16'(want.busy_res), 16'(got.busy_res));
			compare("mem_op", 16'(want.mem_op), 16'(got.mem_op));
			compare("mem_address", want.mem_address, got.mem_address);
			compare("mem_data", 16'(want.mem_data), 16'(got.mem_data));
			compare("done_command", 16'(want.done_command), 16'(got.done_command));
			compare("value_a", want.value_a, got.value_a);
			compare("value_b", 16'(want.value_b), 16'(got.value_b));
			compare("value_c", 16'(want.value_c), 16'(got.value_c));
			compare("value_d", 16'(want.value_d), 16'(got.value_d));
			compare("padding", 16'd0, 16'(bits[79:76]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = MODE_STATUS;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	command_port_model model = new();

	int tx_idle_pct = 11;
	int rx_idle_pct = 64;
	int items_sent = 0;
	int stall_cycles = 0;
	logic [7:0] last_line_lo = 8'h00;
	logic [7:0] last_line_hi = 8'h00;

	text_sprite_command_port dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the reply side at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watch both sides: feed accepted beats to the model and catch a hung port
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				model.note_access(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
			if (m_axis_tvalid && m_axis_tready)
				model.check_reply(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [7:0] random_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_counted();
		case ($urandom_range(4))
			0: return OP_TIMING;
			1: return OP_DISPLAY_ON;
			2: return OP_DISPLAY_DEF;
			3: return OP_CURSOR_DEF;
			default: return OP_SPRITE_ON;
		endcase
	endfunction

	function automatic int run_length(logic [7:0] cmd);
		case (cmd)
			OP_TIMING:      return int'(CNT_SYNC);
			OP_DISPLAY_ON:  return int'(CNT_DSPON);
			OP_DISPLAY_DEF: return int'(CNT_DSPDEF);
			OP_CURSOR_DEF:  return int'(CNT_CURDEF);
			default:        return int'(CNT_SPRON);
		endcase
	endfunction

	// Present one access, idling beforehand at random, and hold it until taken
	task automatic send_access(input logic [1:0] mode, input logic [7:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {7'd0, 1'($urandom_range(1)), data};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Command followed by n parameter bytes, with the odd read mixed in
	task automatic send_counted(input logic [7:0] cmd, input int n);
		logic [7:0] b;
		send_access(MODE_CMD, cmd);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_access($urandom_range(1) ? MODE_STATUS : MODE_DATA, random_byte());
			b = random_byte();
			// repeat the previous line count now and then so it is seen unchanged
			if (cmd == OP_TIMING && i == 10) begin
				if ($urandom_range(2) == 0)
					b = last_line_lo;
				last_line_lo = b;
			end
			if (cmd == OP_TIMING && i == 11) begin
				if ($urandom_range(2) == 0)
					b = last_line_hi;
				last_line_hi = b;
			end
			send_access(MODE_PARAM, b);
		end
	endtask

	task automatic send_sprite_run(input logic [7:0] offset, input int n);
		send_access(MODE_CMD, OP_SPRITE_DEF);
		send_access(MODE_PARAM, offset);
		repeat (n)
			send_access(MODE_PARAM, random_byte());
	endtask

	initial begin
		int target;
		int kind;
		logic [7:0] cmd;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads from reset, a stray parameter, display-on, cursor, sprite-on and sprite-define at their extremes
		send_access(MODE_STATUS, 8'h00);
		send_access(MODE_DATA, 8'hA5);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_CMD, OP_DISPLAY_ON);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_STATUS, 8'hFF);
		send_access(MODE_PARAM, 8'h00);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_CMD, OP_CURSOR_DEF);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_CMD, OP_CURSOR_DEF);
		send_access(MODE_PARAM, 8'h00);
		send_access(MODE_CMD, OP_SPRITE_ON);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_PARAM, 8'h00);
		send_access(MODE_PARAM, 8'hFF);
		// top table page with the top offset: the address wraps to zero
		send_access(MODE_CMD, OP_SPRITE_DEF);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_PARAM, 8'h00);
		send_access(MODE_PARAM, 8'hFF);
		send_access(MODE_CMD, OP_EXIT);
		send_access(MODE_CMD, 8'h00);
		send_access(MODE_STATUS, 8'h00);

		// Random: mostly complete command runs, some cut short, some noise
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 64;
				end
				1: begin
					tx_idle_pct = 64;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				kind = $urandom_range(99);
				if (kind < 60) begin
					cmd = pick_counted();
					send_counted(cmd, run_length(cmd));
				end else if (kind < 72) begin
					send_sprite_run(random_byte(), $urandom_range(1, 8));
				end else if (kind < 80) begin
					repeat ($urandom_range(1, 3))
						send_access($urandom_range(1) ? MODE_STATUS : MODE_DATA,
							random_byte());
				end else if (kind < 88) begin
					cmd = pick_counted();
					send_counted(cmd, $urandom_range(0, run_length(cmd) - 1));
				end else if (kind < 92) begin
					send_access(MODE_CMD, OP_EXIT);
				end else begin
					send_access(2'($urandom_range(3)), 8'($urandom));
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain the outstanding replies, then let the pipeline settle
		while (model.replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d port accesses, %0d decoded commands, %0d memory requests,",
			model.accesses, model.decoded, model.mem_requests);
		$display("under three pacing phases of sender and receiver stalls.");
		if (model.fails == 0 && model.replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tscp_pkg.sv
rtl/core/tscp_decode.sv
rtl/core/text_sprite_command_port.sv
bench/text_sprite_command_port_tb.sv
